### hw/rtl/sorted_timer_queue_macros.svh
// Assertion macros shared by the timer queue RTL.
// Define NO_ASSERTIONS to compile all checks away.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge.
`define STQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorted_timer_queue: invariant violated");

// Check that a condition implies another in the same cycle.
`define STQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_timer_queue: implication violated");

// Check that a condition implies another in the next cycle.
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_timer_queue: sequence violated");

`else

`define STQ_ASSERT(lbl, clk, rst_n, prop)
`define STQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int unsigned SlotW = 4;
  localparam int unsigned MaxResults = 16;

  typedef logic [2:0]         cmd_t;
  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [31:0]        word_t;
  typedef logic signed [31:0] token_t;
  typedef logic [1:0]         status_t;

  localparam cmd_t CMD_ALLOC = 3'd0;
  localparam cmd_t CMD_FREE  = 3'd1;
  localparam cmd_t CMD_BIND  = 3'd2;
  localparam cmd_t CMD_SET   = 3'd3;
  localparam cmd_t CMD_TICK  = 3'd4;

  localparam status_t STAT_ALLOC   = 2'd0;
  localparam status_t STAT_NONE    = 2'd1;
  localparam status_t STAT_EXPIRED = 2'd2;

  typedef enum logic [1:0] {
    ModeFree  = 2'd0,
    ModeAlloc = 2'd1,
    ModeRun   = 2'd2
  } mode_e;

  localparam word_t NoDeadline = 32'hffff_ffff;

endpackage

`default_nettype wire

### hw/rtl/stq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stq_in_if;
  import stq_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  slot_t  slot;
  word_t  timeout;
  token_t token;

  modport source (output valid, output cmd, output slot, output timeout, output token,
                  input ready);
  modport sink   (input valid, input cmd, input slot, input timeout, input token,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/stq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stq_out_if;
  import stq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot_out;
  token_t  token_out;
  logic    last;

  modport source (output valid, output status, output slot_out, output token_out,
                  output last, input ready);
  modport sink   (input valid, input status, input slot_out, input token_out,
                  input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer queue: a pool of SLOT_COUNT timer slots kept in a linked list
// ordered by absolute deadline. One request is taken at a time; req_i.ready is
// high only while the sequencer idles. Allocate returns one response (lowest
// free slot, or a "no free slot" status). Free and bind return nothing. Set
// first unlinks a running slot, then inserts it with deadline tick+timeout,
// walking the list one node per cycle. Tick walks the expired timers from the
// head and holds while rsp_o is stalled; at most 16 timers expire per tick,
// the rest stay at the head for the next tick. The walk speed is set by the
// node memories (deadline, link, token), each with a single registered read
// port, and one shared 32-bit compare used by the insert and expiry steps.
// Expired timers come out in deadline order with last set on the final one; a
// tick with no expiry gives no response. Counter wrap is not handled:
// deadlines compare as plain unsigned values. Equal deadlines go ahead of
// entries already in the list.

`include "sorted_timer_queue_macros.svh"

module sorted_timer_queue #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stq_in_if.sink     req_i,
  stq_out_if.source  rsp_o
);
  import stq_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned KW = (CW > 5) ? CW : 5;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_TO_HEAD  = 4'd2;
  localparam logic [3:0] S_TO_WALK  = 4'd3;
  localparam logic [3:0] S_TO_FIX   = 4'd4;
  localparam logic [3:0] S_IN_START = 4'd5;
  localparam logic [3:0] S_IN_HEAD  = 4'd6;
  localparam logic [3:0] S_IN_WALK  = 4'd7;
  localparam logic [3:0] S_IN_LINK  = 4'd8;
  localparam logic [3:0] S_ALLOC    = 4'd9;
  localparam logic [3:0] S_TK_START = 4'd10;
  localparam logic [3:0] S_TK_CHECK = 4'd11;

  logic [3:0] state_q, state_d;

  // Latched request.
  cmd_t   cmd_q;
  slot_t  slot_q;
  word_t  tmo_q;
  token_t tok_q;

  // List bookkeeping.
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  word_t         tick_q, tick_d;
  word_t         earliest_q, earliest_d;
  word_t         dl_q, dl_d;
  logic [IW-1:0] p_q, p_d;
  logic [IW-1:0] n_q, n_d;
  logic [KW-1:0] walk_q, walk_d;
  mode_e         mode_q [SLOT_COUNT];
  mode_e         mode_d [SLOT_COUNT];

  // Pending expiry held until the next one tells whether it is the last.
  logic          pend_v_q, pend_v_d;
  logic [IW-1:0] pend_slot_q, pend_slot_d;
  token_t        pend_tok_q, pend_tok_d;

  // Output register.
  logic    out_v_q, out_v_d;
  status_t out_status_q, out_status_d;
  slot_t   out_slot_q, out_slot_d;
  token_t  out_tok_q, out_tok_d;
  logic    out_last_q, out_last_d;

  // Node memory ports.
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  word_t         rd_dl;
  logic [IW-1:0] rd_link;
  token_t        rd_tok;
  logic          dl_we;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic          tok_we;

  logic          req_accept;
  logic [IW-1:0] s_idx;
  logic          slot_ok;
  logic          can_push;
  logic [CW-1:0] remain;

  logic [SLOT_COUNT-1:0] free_vec;
  logic                  alloc_found;
  logic [IW-1:0]         alloc_idx;

  // Shared compare unit: a <= b, operands chosen by state.
  word_t cmp_a, cmp_b;
  logic  cmp_le;

  logic    push;
  status_t push_status;
  slot_t   push_slot;
  token_t  push_tok;
  logic    push_last;

  assign req_accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign s_idx    = IW'(slot_q);
  assign slot_ok  = (7'(slot_q) < 7'(SLOT_COUNT));
  assign can_push = !out_v_q || rsp_o.ready;
  assign remain   = count_q - CW'(walk_q);

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.slot_out  = out_slot_q;
  assign rsp_o.token_out = out_tok_q;
  assign rsp_o.last      = out_last_q;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_vec[i] = (mode_q[i] == ModeFree);
    end
  end

  stq_alloc #(
    .SlotCount (SLOT_COUNT)
  ) u_alloc (
    .free_i  (free_vec),
    .found_o (alloc_found),
    .idx_o   (alloc_idx)
  );

  always_comb begin
    case (state_q)
      S_TK_START: begin
        cmp_a = earliest_q;
        cmp_b = tick_q;
      end
      S_TK_CHECK: begin
        cmp_a = rd_dl;
        cmp_b = tick_q;
      end
      default: begin
        cmp_a = dl_q;
        cmp_b = rd_dl;
      end
    endcase
  end

  assign cmp_le = (cmp_a <= cmp_b);

  stq_ram #(
    .Width (32),
    .Depth (SLOT_COUNT)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (s_idx),
    .wdata_i (dl_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_dl)
  );

  stq_ram #(
    .Width (IW),
    .Depth (SLOT_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_link)
  );

  stq_ram #(
    .Width (32),
    .Depth (SLOT_COUNT)
  ) u_token_ram (
    .clk_i   (clk_i),
    .we_i    (tok_we),
    .waddr_i (s_idx),
    .wdata_i (tok_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_tok)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    tick_d      = tick_q;
    earliest_d  = earliest_q;
    dl_d        = dl_q;
    p_d         = p_q;
    n_d         = n_q;
    walk_d      = walk_q;
    mode_d      = mode_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_tok_d  = pend_tok_q;

    rd_en      = 1'b0;
    rd_addr    = head_q;
    dl_we      = 1'b0;
    link_we    = 1'b0;
    link_waddr = p_q;
    link_wdata = s_idx;
    tok_we     = 1'b0;

    push        = 1'b0;
    push_status = STAT_EXPIRED;
    push_slot   = SlotW'(pend_slot_q);
    push_tok    = pend_tok_q;
    push_last   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        state_d = S_IDLE;
        case (cmd_q)
          CMD_ALLOC: begin
            state_d = S_ALLOC;
          end
          CMD_FREE: begin
            // A running slot stays running.
            if (slot_ok && (mode_q[s_idx] != ModeRun)) begin
              mode_d[s_idx] = ModeFree;
            end
          end
          CMD_BIND: begin
            tok_we = slot_ok;
          end
          CMD_SET: begin
            if (slot_ok) begin
              dl_d = tick_q + tmo_q;
              if (mode_q[s_idx] == ModeRun) begin
                // Unlink first, then insert with the new deadline.
                if (head_q == s_idx) begin
                  rd_en   = 1'b1;
                  rd_addr = s_idx;
                  state_d = S_TO_HEAD;
                end else if (count_q > CW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = head_q;
                  p_d     = head_q;
                  walk_d  = KW'(1);
                  state_d = S_TO_WALK;
                end else begin
                  state_d = S_IN_START;
                end
              end else begin
                state_d = S_IN_START;
              end
            end
          end
          CMD_TICK: begin
            tick_d  = tick_q + 32'd1;
            state_d = S_TK_START;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_TO_HEAD: begin
        // Drop the head: its successor becomes the head.
        head_d  = rd_link;
        count_d = count_q - CW'(1);
        state_d = S_IN_START;
      end

      S_TO_WALK: begin
        if (rd_link == s_idx) begin
          rd_en   = 1'b1;
          rd_addr = s_idx;
          state_d = S_TO_FIX;
        end else begin
          p_d    = rd_link;
          walk_d = walk_q + KW'(1);
          if ((walk_q + KW'(1)) < KW'(count_q)) begin
            rd_en   = 1'b1;
            rd_addr = rd_link;
          end else begin
            state_d = S_IN_START;
          end
        end
      end

      S_TO_FIX: begin
        // Bridge the predecessor over the removed slot.
        link_we    = 1'b1;
        link_waddr = p_q;
        link_wdata = rd_link;
        count_d    = count_q - CW'(1);
        state_d    = S_IN_START;
      end

      S_IN_START: begin
        dl_we         = 1'b1;
        mode_d[s_idx] = ModeRun;
        if (count_q == '0) begin
          head_d     = s_idx;
          count_d    = CW'(1);
          earliest_d = dl_q;
          state_d    = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = S_IN_HEAD;
        end
      end

      S_IN_HEAD: begin
        earliest_d = cmp_le ? dl_q : rd_dl;
        if (cmp_le) begin
          link_we    = 1'b1;
          link_waddr = s_idx;
          link_wdata = head_q;
          head_d     = s_idx;
          count_d    = count_q + CW'(1);
          state_d    = S_IDLE;
        end else if (count_q > CW'(1)) begin
          p_d     = head_q;
          n_d     = rd_link;
          walk_d  = KW'(1);
          rd_en   = 1'b1;
          rd_addr = rd_link;
          state_d = S_IN_WALK;
        end else begin
          link_we    = 1'b1;
          link_waddr = head_q;
          link_wdata = s_idx;
          count_d    = count_q + CW'(1);
          state_d    = S_IDLE;
        end
      end

      S_IN_WALK: begin
        if (cmp_le) begin
          // Insert between p and n: p -> s here, s -> n next cycle.
          link_we    = 1'b1;
          link_waddr = p_q;
          link_wdata = s_idx;
          state_d    = S_IN_LINK;
        end else if ((walk_q + KW'(1)) < KW'(count_q)) begin
          p_d     = n_q;
          n_d     = rd_link;
          walk_d  = walk_q + KW'(1);
          rd_en   = 1'b1;
          rd_addr = rd_link;
        end else begin
          // Append at the tail.
          link_we    = 1'b1;
          link_waddr = n_q;
          link_wdata = s_idx;
          count_d    = count_q + CW'(1);
          state_d    = S_IDLE;
        end
      end

      S_IN_LINK: begin
        link_we    = 1'b1;
        link_waddr = s_idx;
        link_wdata = n_q;
        count_d    = count_q + CW'(1);
        state_d    = S_IDLE;
      end

      S_ALLOC: begin
        if (can_push) begin
          push        = 1'b1;
          push_status = alloc_found ? STAT_ALLOC : STAT_NONE;
          push_slot   = alloc_found ? SlotW'(alloc_idx) : '0;
          push_tok    = '0;
          push_last   = 1'b1;
          if (alloc_found) begin
            mode_d[alloc_idx] = ModeAlloc;
          end
          state_d = S_IDLE;
        end
      end

      S_TK_START: begin
        if (cmp_le) begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          p_d     = head_q;
          walk_d  = '0;
          state_d = S_TK_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_TK_CHECK: begin
        // Hold the node read while the previous expiry waits for the output.
        if (!(pend_v_q && !can_push)) begin
          if (pend_v_q) begin
            push      = 1'b1;
            push_last = !((walk_q < KW'(count_q)) && (walk_q < KW'(MaxResults)) && cmp_le);
            pend_v_d  = 1'b0;
          end
          if ((walk_q < KW'(count_q)) && (walk_q < KW'(MaxResults)) && cmp_le) begin
            pend_v_d      = 1'b1;
            pend_slot_d   = p_q;
            pend_tok_d    = rd_tok;
            mode_d[p_q]   = ModeAlloc;
            walk_d        = walk_q + KW'(1);
            p_d           = rd_link;
            rd_en         = 1'b1;
            rd_addr       = rd_link;
          end else begin
            count_d    = remain;
            head_d     = (remain != '0) ? p_q : '0;
            earliest_d = (remain != '0) ? rd_dl : NoDeadline;
            state_d    = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_v_d      = out_v_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_tok_d    = out_tok_q;
    out_last_d   = out_last_q;
    if (push) begin
      out_v_d      = 1'b1;
      out_status_d = push_status;
      out_slot_d   = push_slot;
      out_tok_d    = push_tok;
      out_last_d   = push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      tick_q     <= '0;
      earliest_q <= NoDeadline;
      p_q        <= '0;
      n_q        <= '0;
      walk_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode_q[i] <= ModeFree;
      end
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      tick_q     <= tick_d;
      earliest_q <= earliest_d;
      p_q        <= p_d;
      n_q        <= n_d;
      walk_q     <= walk_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      mode_q     <= mode_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      cmd_q  <= req_i.cmd;
      slot_q <= req_i.slot;
      tmo_q  <= req_i.timeout;
      tok_q  <= req_i.token;
    end
    dl_q         <= dl_d;
    pend_slot_q  <= pend_slot_d;
    pend_tok_q   <= pend_tok_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_tok_q    <= out_tok_d;
    out_last_q   <= out_last_d;
  end

  // The list never holds more timers than there are slots.
  `STQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(SLOT_COUNT))
  // An idle, empty list always reports no deadline.
  `STQ_ASSERT_IMPL(a_empty_deadline, clk_i, rst_ni, (state_q == S_IDLE) && (count_q == '0), earliest_q == NoDeadline)
  // A held expiry exists only during the expiry walk.
  `STQ_ASSERT_IMPL(a_pend_walk, clk_i, rst_ni, pend_v_q, state_q == S_TK_CHECK)
  // Allocate responses are single and always final.
  `STQ_ASSERT_IMPL(a_alloc_last, clk_i, rst_ni, out_v_q && (out_status_q != STAT_EXPIRED), out_last_q)
  // An accepted request is decoded in the next cycle.
  `STQ_ASSERT_NEXT(a_req_disp, clk_i, rst_ni, req_i.valid && req_i.ready, state_q == S_DISP)

endmodule

`default_nettype wire

### hw/rtl/stq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/stq_alloc.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_alloc #(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned IdxW      = $clog2(SlotCount)
) (
  input  logic [SlotCount-1:0] free_i,
  output logic                 found_o,
  output logic [IdxW-1:0]      idx_o
);

  // Pick the lowest-numbered free slot.
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire
